FILE: sv/vtm_pkg.sv
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types, register codes and defaults for the video transition mixer.
// ----------------------------------------------------------------------------
package vtm_pkg;

  localparam int unsigned STEPS_DEF   = 20;
  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned BANDH_W    = 12;
  localparam int unsigned FILL_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned NUM_CH     = 3;

  typedef enum logic [1:0] {
    MODE_DISSOLVE   = 2'd0,
    MODE_WIPE_LEFT  = 2'd1,
    MODE_WIPE_RIGHT = 2'd2,
    MODE_BOX        = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_BAND_WIDTH   = 3'd3,
    REG_BAND_HEIGHT  = 3'd4,
    REG_FILL_COLOUR  = 3'd5
  } cfg_reg_e;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0]   BAND_WIDTH_RST   = 13'd32;
  localparam logic [BANDH_W-1:0] BAND_HEIGHT_RST  = 12'd12;
  localparam logic [FILL_W-1:0]  FILL_COLOUR_RST  = 24'd1;

  typedef struct packed {
    mode_e                mode;
    logic [DIM_W-1:0]     frame_width;
    logic [DIM_W-1:0]     frame_height;
    logic [DIM_W-1:0]     band_width;
    logic [BANDH_W-1:0]   band_height;
    logic [FILL_W-1:0]    fill_colour;
  } cfg_t;

  // per-stage load enables
  typedef struct packed {
    logic a_en;
    logic b_en;
    logic c_en;
  } pipe_en_t;

endpackage

FILE: sv/video_transition_mixer.sv
// ----------------------------------------------------------------------------
// video_transition_mixer
// Each input beat moves through the stage A, B and C registers to the output.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// three-register pipeline whose stages all advance when the output register
// frees up. Reset clears all stage valid bits and loads register defaults.
// Per-pixel dissolve, wipe and box mixer of an old and a new frame.
// ----------------------------------------------------------------------------
module video_transition_mixer #(
  parameter int unsigned STEPS   = vtm_pkg::STEPS_DEF,
  parameter int unsigned MAX_DIM = vtm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_we_i,
  input  logic [vtm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vtm_pkg::CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [vtm_pkg::COORD_W-1:0]     pixel_x_i,
  input  logic [vtm_pkg::COORD_W-1:0]     pixel_y_i,
  input  logic [vtm_pkg::STEP_W-1:0]      step_index_i,
  input  logic [vtm_pkg::PIX_W-1:0]       old_blue_i,
  input  logic [vtm_pkg::PIX_W-1:0]       old_green_i,
  input  logic [vtm_pkg::PIX_W-1:0]       old_red_i,
  input  logic [vtm_pkg::PIX_W-1:0]       new_blue_i,
  input  logic [vtm_pkg::PIX_W-1:0]       new_green_i,
  input  logic [vtm_pkg::PIX_W-1:0]       new_red_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [vtm_pkg::PIX_W-1:0]       out_blue_o,
  output logic [vtm_pkg::PIX_W-1:0]       out_green_o,
  output logic [vtm_pkg::PIX_W-1:0]       out_red_o
);

  vtm_pkg::cfg_t      cfg;
  vtm_pkg::pipe_en_t  en;
  logic               a_valid_q, b_valid_q, c_valid_q;
  logic               a_valid_d, b_valid_d, c_valid_d;

  vtm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en.c_en   = !c_valid_q || !out_stall_i;
    en.b_en   = !b_valid_q || en.c_en;
    en.a_en   = !a_valid_q || en.b_en;
    a_valid_d = en.a_en ? in_valid_i : a_valid_q;
    b_valid_d = en.b_en ? a_valid_q  : b_valid_q;
    c_valid_d = en.c_en ? b_valid_q  : c_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
    end
  end

  assign in_stall_o  = !en.a_en;
  assign out_valid_o = c_valid_q;

  vtm_datapath #(
    .STEPS   (STEPS),
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .en_i         (en),
    .cfg_i        (cfg),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .step_index_i (step_index_i),
    .old_blue_i   (old_blue_i),
    .old_green_i  (old_green_i),
    .old_red_i    (old_red_i),
    .new_blue_i   (new_blue_i),
    .new_green_i  (new_green_i),
    .new_red_i    (new_red_i),
    .out_blue_o   (out_blue_o),
    .out_green_o  (out_green_o),
    .out_red_o    (out_red_o)
  );

endmodule

FILE: sv/vtm_cfg.sv
// ----------------------------------------------------------------------------
// vtm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module vtm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vtm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vtm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output vtm_pkg::cfg_t                      cfg_o
);

  vtm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vtm_pkg::cfg_reg_e'(cfg_idx_i))
        vtm_pkg::REG_MODE: begin
          cfg_d.mode = vtm_pkg::mode_e'(cfg_data_i[1:0]);
        end
        vtm_pkg::REG_FRAME_WIDTH: begin
          cfg_d.frame_width = cfg_data_i[vtm_pkg::DIM_W-1:0];
        end
        vtm_pkg::REG_FRAME_HEIGHT: begin
          cfg_d.frame_height = cfg_data_i[vtm_pkg::DIM_W-1:0];
        end
        vtm_pkg::REG_BAND_WIDTH: begin
          cfg_d.band_width = cfg_data_i[vtm_pkg::DIM_W-1:0];
        end
        vtm_pkg::REG_BAND_HEIGHT: begin
          cfg_d.band_height = cfg_data_i[vtm_pkg::BANDH_W-1:0];
        end
        vtm_pkg::REG_FILL_COLOUR: begin
          cfg_d.fill_colour = cfg_data_i[vtm_pkg::FILL_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= vtm_pkg::MODE_DISSOLVE;
      cfg_q.frame_width  <= vtm_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height <= vtm_pkg::FRAME_HEIGHT_RST;
      cfg_q.band_width   <= vtm_pkg::BAND_WIDTH_RST;
      cfg_q.band_height  <= vtm_pkg::BAND_HEIGHT_RST;
      cfg_q.fill_colour  <= vtm_pkg::FILL_COLOUR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/vtm_datapath.sv
// ----------------------------------------------------------------------------
// vtm_datapath
// Three-stage pixel datapath: input register, weights and band products,
// then reciprocal divide, reveal compare and output select.
// ----------------------------------------------------------------------------
module vtm_datapath #(
  parameter int unsigned STEPS   = vtm_pkg::STEPS_DEF,
  parameter int unsigned MAX_DIM = vtm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  vtm_pkg::pipe_en_t             en_i,
  input  vtm_pkg::cfg_t                 cfg_i,
  input  logic [vtm_pkg::COORD_W-1:0]   pixel_x_i,
  input  logic [vtm_pkg::COORD_W-1:0]   pixel_y_i,
  input  logic [vtm_pkg::STEP_W-1:0]    step_index_i,
  input  logic [vtm_pkg::PIX_W-1:0]     old_blue_i,
  input  logic [vtm_pkg::PIX_W-1:0]     old_green_i,
  input  logic [vtm_pkg::PIX_W-1:0]     old_red_i,
  input  logic [vtm_pkg::PIX_W-1:0]     new_blue_i,
  input  logic [vtm_pkg::PIX_W-1:0]     new_green_i,
  input  logic [vtm_pkg::PIX_W-1:0]     new_red_i,
  output logic [vtm_pkg::PIX_W-1:0]     out_blue_o,
  output logic [vtm_pkg::PIX_W-1:0]     out_green_o,
  output logic [vtm_pkg::PIX_W-1:0]     out_red_o
);

  localparam int unsigned PIX_W   = vtm_pkg::PIX_W;
  localparam int unsigned NUM_CH  = vtm_pkg::NUM_CH;
  localparam int unsigned S_W     = $clog2(STEPS + 1);
  localparam int unsigned CMP_W   = (S_W > vtm_pkg::STEP_W) ? S_W : vtm_pkg::STEP_W;
  localparam int unsigned SUM_W   = PIX_W + S_W;
  // exact floor division by STEPS for any sum below 2**SUM_W
  localparam int unsigned SHIFT   = SUM_W + $clog2(STEPS);
  localparam int unsigned RECIP   = ((1 << SHIFT) + STEPS - 1) / STEPS;
  localparam int unsigned PROD_W  = 2 * SUM_W + 1;
  localparam int unsigned PW      = S_W + vtm_pkg::DIM_W + 1;
  localparam int unsigned MD_W    = $clog2(MAX_DIM + 1);
  localparam int unsigned CL_W    = (MD_W > vtm_pkg::DIM_W) ? MD_W : vtm_pkg::DIM_W;

  // stage A
  logic [vtm_pkg::COORD_W-1:0]   x_a_q, y_a_q;
  logic [vtm_pkg::STEP_W-1:0]    s_a_q;
  logic [NUM_CH-1:0][PIX_W-1:0]  old_a_q, new_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i.a_en) begin
      x_a_q   <= pixel_x_i;
      y_a_q   <= pixel_y_i;
      s_a_q   <= step_index_i;
      old_a_q <= {old_red_i, old_green_i, old_blue_i};
      new_a_q <= {new_red_i, new_green_i, new_blue_i};
    end
  end

  // stage B: saturated step, blend weights, band products
  logic [CMP_W-1:0]              s_ext;
  logic [S_W-1:0]                s_sat, wt_old;
  logic [NUM_CH-1:0][SUM_W-1:0]  sum_d, sum_b_q;
  logic [PW-1:0]                 sbw_d, hx_d, hy_d;
  logic [PW-1:0]                 sbw_b_q, hx_b_q, hy_b_q;
  logic [vtm_pkg::COORD_W-1:0]   x_b_q, y_b_q;
  logic [NUM_CH-1:0][PIX_W-1:0]  new_b_q;

  always_comb begin
    s_ext  = CMP_W'(s_a_q);
    s_sat  = (s_ext > CMP_W'(STEPS)) ? S_W'(STEPS) : S_W'(s_ext);
    wt_old = S_W'(STEPS) - s_sat;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_d[ch] = SUM_W'(old_a_q[ch]) * SUM_W'(wt_old)
                + SUM_W'(new_a_q[ch]) * SUM_W'(s_sat)
                + SUM_W'(STEPS / 2);
    end
    sbw_d = PW'(s_sat) * PW'(cfg_i.band_width);
    hx_d  = PW'(s_sat) * PW'(cfg_i.band_width >> 1);
    hy_d  = PW'(s_sat) * PW'(cfg_i.band_height);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b_en) begin
      sum_b_q <= sum_d;
      sbw_b_q <= sbw_d;
      hx_b_q  <= hx_d;
      hy_b_q  <= hy_d;
      x_b_q   <= x_a_q;
      y_b_q   <= y_a_q;
      new_b_q <= new_a_q;
    end
  end

  // stage C: divide, reveal, select
  logic [CL_W-1:0]               w_ext, h_ext, w_cl, h_cl;
  logic [PW-1:0]                 x_p, y_p, cx, cy;
  logic                          reveal;
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  logic [NUM_CH-1:0][PIX_W-1:0]  quot, fill, out_d, out_q;

  always_comb begin
    w_ext = CL_W'(cfg_i.frame_width);
    h_ext = CL_W'(cfg_i.frame_height);
    w_cl  = (w_ext > CL_W'(MAX_DIM)) ? CL_W'(MAX_DIM) : w_ext;
    h_cl  = (h_ext > CL_W'(MAX_DIM)) ? CL_W'(MAX_DIM) : h_ext;
    cx    = PW'(w_cl >> 1);
    cy    = PW'(h_cl >> 1);
    x_p   = PW'(x_b_q);
    y_p   = PW'(y_b_q);

    unique case (cfg_i.mode)
      vtm_pkg::MODE_WIPE_LEFT: begin
        reveal = x_p < sbw_b_q;
      end
      vtm_pkg::MODE_WIPE_RIGHT: begin
        reveal = (x_p + sbw_b_q) >= PW'(w_cl);
      end
      vtm_pkg::MODE_BOX: begin
        reveal = ((x_p + hx_b_q) >= cx) && (x_p < (cx + hx_b_q)) &&
                 ((y_p + hy_b_q) >= cy) && (y_p < (cy + hy_b_q));
      end
      default: begin
        reveal = 1'b0;
      end
    endcase

    fill = cfg_i.fill_colour;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(sum_b_q[ch]) * PROD_W'(RECIP);
      quot[ch] = prod[ch][SHIFT +: PIX_W];
      if (cfg_i.mode == vtm_pkg::MODE_DISSOLVE) begin
        out_d[ch] = quot[ch];
      end else if (reveal) begin
        out_d[ch] = new_b_q[ch];
      end else begin
        out_d[ch] = fill[ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c_en) begin
      out_q <= out_d;
    end
  end

  assign out_blue_o  = out_q[0];
  assign out_green_o = out_q[1];
  assign out_red_o   = out_q[2];

endmodule

FILE: sv/vtm_checker.sv
// ----------------------------------------------------------------------------
// vtm_checker
// Port-level checks on the mixer handshake, bound to the top level.
// ----------------------------------------------------------------------------
module vtm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [vtm_pkg::PIX_W-1:0]  out_blue_o,
  input logic [vtm_pkg::PIX_W-1:0]  out_green_o,
  input logic [vtm_pkg::PIX_W-1:0]  out_red_o
);

  // no output beat while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // input backs up only when the output beat is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // an accepted beat reaches the output when the output is not stalled while
  // it moves from stage A to stage B and from stage B to stage C
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("accepted beat lost in pipeline");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_blue_o) && $stable(out_green_o) &&
       $stable(out_red_o)))
    else $error("stalled output beat changed");

endmodule

bind video_transition_mixer vtm_checker u_vtm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_blue_o  (out_blue_o),
  .out_green_o (out_green_o),
  .out_red_o   (out_red_o)
);

FILE: tb/tb_video_transition_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_transition_mixer
// Self-checking bench for the per-pixel dissolve / wipe / box transition mixer.
// Each accepted input beat is run through a local mixing predictor that uses
// the bench's copy of the registers. The expected pixel is queued, and every
// output beat is checked against the oldest queued pixel. The run starts with
// directed rounding, band-edge and degenerate-size cases. It then runs random
// register settings, with pixels aimed mostly at the reveal boundaries, and
// ends with a stretch at full rate. Input gaps and output stalls come in
// random bursts.
// ----------------------------------------------------------------------------
module tb_video_transition_mixer;
  import vtm_pkg::*;

  localparam int unsigned STEPS          = STEPS_DEF;
  localparam int unsigned MAX_DIM        = MAX_DIM_DEF;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASES         = 12;
  localparam int          PHASE_BEATS    = 125;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STEP_W-1:0]  step;
    logic [PIX_W-1:0]   old_b;
    logic [PIX_W-1:0]   old_g;
    logic [PIX_W-1:0]   old_r;
    logic [PIX_W-1:0]   new_b;
    logic [PIX_W-1:0]   new_g;
    logic [PIX_W-1:0]   new_r;
  } pixel_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic [STEP_W-1:0]  step_index = '0;
  logic [PIX_W-1:0]   old_blue = '0;
  logic [PIX_W-1:0]   old_green = '0;
  logic [PIX_W-1:0]   old_red = '0;
  logic [PIX_W-1:0]   new_blue = '0;
  logic [PIX_W-1:0]   new_green = '0;
  logic [PIX_W-1:0]   new_red = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   out_blue;
  logic [PIX_W-1:0]   out_green;
  logic [PIX_W-1:0]   out_red;

  cfg_t mix_cfg = '{MODE_DISSOLVE, FRAME_WIDTH_RST, FRAME_HEIGHT_RST,
                    BAND_WIDTH_RST, BAND_HEIGHT_RST, FILL_COLOUR_RST};

  rgb_t mixed_q[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_settings = 1;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  video_transition_mixer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .step_index_i (step_index),
    .old_blue_i   (old_blue),
    .old_green_i  (old_green),
    .old_red_i    (old_red),
    .new_blue_i   (new_blue),
    .new_green_i  (new_green),
    .new_red_i    (new_red),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_blue_o   (out_blue),
    .out_green_o  (out_green),
    .out_red_o    (out_red)
  );

  always #5 clk = ~clk;

  // ---- predictor ----

  function automatic logic [PIX_W-1:0] fade(longint o, longint n, longint s);
    longint t;
    t = (o * (STEPS - s) + n * s + STEPS / 2) / STEPS;
    return t[PIX_W-1:0];
  endfunction

  function automatic rgb_t mix_pixel(pixel_beat_t p);
    longint s, w, h, bw, bh, x, y, cx, cy, hx, hy;
    bit     show_new;
    rgb_t   r;
    s  = (p.step > STEPS) ? STEPS : p.step;
    w  = (mix_cfg.frame_width > MAX_DIM) ? MAX_DIM : mix_cfg.frame_width;
    h  = (mix_cfg.frame_height > MAX_DIM) ? MAX_DIM : mix_cfg.frame_height;
    bw = mix_cfg.band_width;
    bh = mix_cfg.band_height;
    x  = p.x;
    y  = p.y;
    show_new = 1'b0;
    case (mix_cfg.mode)
      MODE_DISSOLVE: begin
        r.blue  = fade(p.old_b, p.new_b, s);
        r.green = fade(p.old_g, p.new_g, s);
        r.red   = fade(p.old_r, p.new_r, s);
        return r;
      end
      MODE_WIPE_LEFT:  show_new = x < s * bw;
      MODE_WIPE_RIGHT: show_new = x + s * bw >= w;
      default: begin
        cx = w / 2;
        cy = h / 2;
        hx = (bw / 2) * s;
        hy = bh * s;
        show_new = x >= cx - hx && x < cx + hx && y >= cy - hy && y < cy + hy;
      end
    endcase
    if (show_new) begin
      r.blue  = p.new_b;
      r.green = p.new_g;
      r.red   = p.new_r;
    end else begin
      r.blue  = mix_cfg.fill_colour[7:0];
      r.green = mix_cfg.fill_colour[15:8];
      r.red   = mix_cfg.fill_colour[23:16];
    end
    return r;
  endfunction

  function automatic void store_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
    case (r)
      REG_MODE:         mix_cfg.mode = mode_e'(d[1:0]);
      REG_FRAME_WIDTH:  mix_cfg.frame_width = d[DIM_W-1:0];
      REG_FRAME_HEIGHT: mix_cfg.frame_height = d[DIM_W-1:0];
      REG_BAND_WIDTH:   mix_cfg.band_width = d[DIM_W-1:0];
      REG_BAND_HEIGHT:  mix_cfg.band_height = d[BANDH_W-1:0];
      REG_FILL_COLOUR:  mix_cfg.fill_colour = d[FILL_W-1:0];
      default: ;
    endcase
  endfunction

  // ---- stimulus helpers ----

  function automatic pixel_beat_t make_beat(int x, int y, int s,
                                            logic [23:0] old_px, logic [23:0] new_px);
    pixel_beat_t p;
    p.x     = COORD_W'(x);
    p.y     = COORD_W'(y);
    p.step  = STEP_W'(s);
    p.old_b = old_px[7:0];
    p.old_g = old_px[15:8];
    p.old_r = old_px[23:16];
    p.new_b = new_px[7:0];
    p.new_g = new_px[15:8];
    p.new_r = new_px[23:16];
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(longint t);
    longint v;
    v = t + longint'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    else if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return v[COORD_W-1:0];
  endfunction

  // In the wipe and box modes, mostly lands on a reveal boundary of the current setting.
  function automatic pixel_beat_t rand_pixel();
    pixel_beat_t p;
    logic [95:0] raw;
    longint s, w, h, bw, bh;
    raw = {$urandom(), $urandom(), $urandom()};
    p = raw[$bits(pixel_beat_t)-1:0];
    if ($urandom_range(0, 9) != 0) p.step = STEP_W'($urandom_range(0, STEPS));
    s  = (p.step > STEPS) ? STEPS : p.step;
    w  = (mix_cfg.frame_width > MAX_DIM) ? MAX_DIM : mix_cfg.frame_width;
    h  = (mix_cfg.frame_height > MAX_DIM) ? MAX_DIM : mix_cfg.frame_height;
    bw = mix_cfg.band_width;
    bh = mix_cfg.band_height;
    if ($urandom_range(0, 9) < 6) begin
      case (mix_cfg.mode)
        MODE_WIPE_LEFT:  p.x = near_coord(s * bw);
        MODE_WIPE_RIGHT: p.x = near_coord(w - s * bw);
        MODE_BOX: begin
          if ($urandom_range(0, 1)) p.x = near_coord(w / 2 + (bw / 2) * s);
          else p.x = near_coord(w / 2 - (bw / 2) * s);
          if ($urandom_range(0, 1)) p.y = near_coord(h / 2 + bh * s);
          else p.y = near_coord(h / 2 - bh * s);
        end
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic send_pixel(pixel_beat_t p);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    pixel_x    <= p.x;
    pixel_y    <= p.y;
    step_index <= p.step;
    old_blue   <= p.old_b;
    old_green  <= p.old_g;
    old_red    <= p.old_r;
    new_blue   <= p.new_b;
    new_green  <= p.new_g;
    new_red    <= p.new_r;
    do @(posedge clk); while (in_stall);
    mixed_q = {mixed_q, mix_pixel(p)};
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(mode_e m, logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh,
                               logic [DIM_W-1:0] bw, logic [BANDH_W-1:0] bh,
                               logic [FILL_W-1:0] fill);
    logic [CFG_DATA_W-1:0] vals [6];
    cfg_reg_e              r;
    int                    i;
    vals[REG_MODE]         = CFG_DATA_W'(m);
    vals[REG_FRAME_WIDTH]  = CFG_DATA_W'(fw);
    vals[REG_FRAME_HEIGHT] = CFG_DATA_W'(fh);
    vals[REG_BAND_WIDTH]   = CFG_DATA_W'(bw);
    vals[REG_BAND_HEIGHT]  = CFG_DATA_W'(bh);
    vals[REG_FILL_COLOUR]  = CFG_DATA_W'(fill);
    wait_idle();
    for (i = 0; i < 6; i++) begin
      r = cfg_reg_e'(i);
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= vals[i];
      store_reg(r, vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // ---- tests ----

  // reset settings: dissolve, step zero, saturation, half rounding
  task automatic test_dissolve_rounding();
    send_pixel(make_beat(0, 0, 0, 24'hFFFFFF, 24'h000000));
    send_pixel(make_beat(4095, 4095, 20, 24'h000000, 24'hFFFFFF));
    send_pixel(make_beat(100, 7, 31, 24'hAA55AA, 24'h55AA55));
    send_pixel(make_beat(5, 5, 10, 24'h01FF00, 24'h000001));
    send_pixel(make_beat(2730, 1365, 1, 24'hFFFFFF, 24'hFFFFFF));
  endtask

  task automatic test_wipe_edges();
    load_settings(MODE_WIPE_LEFT, 640, 480, 32, 12, 24'hA5C35A);
    send_pixel(make_beat(95, 0, 3, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(96, 0, 3, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(0, 0, 0, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(639, 479, 31, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(4095, 0, 20, 24'h112233, 24'hCCDDEE));
    // width above the frame limit saturates
    load_settings(MODE_WIPE_RIGHT, 8191, 480, 32, 12, 24'h5A3CA5);
    send_pixel(make_beat(4064, 0, 1, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(4063, 0, 1, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(4095, 0, 0, 24'h112233, 24'hCCDDEE));
  endtask

  task automatic test_box_edges();
    load_settings(MODE_BOX, 640, 480, 33, 12, 24'hFFFFFF);
    send_pixel(make_beat(288, 216, 2, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(351, 263, 2, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(352, 240, 2, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(320, 264, 2, 24'h112233, 24'hCCDDEE));
    send_pixel(make_beat(287, 240, 2, 24'h112233, 24'hCCDDEE));
  endtask

  task automatic test_degenerate_sizes();
    load_settings(MODE_BOX, 0, 0, 0, 0, 24'h000000);
    send_pixel(make_beat(0, 0, 20, 24'h112233, 24'hCCDDEE));
    load_settings(MODE_WIPE_LEFT, 640, 480, 0, 12, 24'h3C3C3C);
    send_pixel(make_beat(0, 0, 20, 24'h112233, 24'hCCDDEE));
    load_settings(MODE_WIPE_RIGHT, 0, 480, 0, 12, 24'hC3C3C3);
    send_pixel(make_beat(0, 0, 0, 24'h112233, 24'hCCDDEE));
  endtask

  task automatic test_random_mixes();
    int ph, i, fw, fh, bw, bh;
    for (ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       fw = 1;
        1:       fw = MAX_DIM;
        2:       fw = (1 << DIM_W) - 1;
        default: fw = $urandom_range(1, MAX_DIM);
      endcase
      case ($urandom_range(0, 5))
        0:       fh = 1;
        1:       fh = MAX_DIM;
        2:       fh = (1 << DIM_W) - 1;
        default: fh = $urandom_range(1, MAX_DIM);
      endcase
      case ($urandom_range(0, 5))
        0:       bw = 0;
        1:       bw = (1 << DIM_W) - 1;
        2:       bw = $urandom_range(0, MAX_DIM);
        default: bw = $urandom_range(1, 300);
      endcase
      case ($urandom_range(0, 5))
        0:       bh = 0;
        1:       bh = (1 << BANDH_W) - 1;
        2:       bh = $urandom_range(0, 2048);
        default: bh = $urandom_range(1, 120);
      endcase
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 40;
      endcase
      load_settings(mode_e'(ph % 4), DIM_W'(fw), DIM_W'(fh), DIM_W'(bw), BANDH_W'(bh),
                    FILL_W'($urandom()));
      for (i = 0; i < PHASE_BEATS; i++) begin
        send_pixel(rand_pixel());
        if (ph == PHASES / 2 && i == PHASE_BEATS / 2) wait_idle();
      end
    end
  endtask

  task automatic test_full_rate();
    int i;
    gap_pct   = 0;
    stall_pct = 0;
    load_settings(MODE_DISSOLVE, 640, 480, 32, 12, FILL_W'($urandom()));
    for (i = 0; i < 130; i++) send_pixel(rand_pixel());
    load_settings(MODE_BOX, 1920, 1080, 96, 27, FILL_W'($urandom()));
    for (i = 0; i < 130; i++) send_pixel(rand_pixel());
  endtask

  // ---- output side ----

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mixed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output beat: b/g/r %02h/%02h/%02h",
                   out_blue, out_green, out_red);
      end else begin
        want = mixed_q.pop_front();
        if (out_blue !== want.blue || out_green !== want.green || out_red !== want.red) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d: expected b/g/r %02h/%02h/%02h, got %02h/%02h/%02h",
                     n_checked, want.blue, want.green, want.red,
                     out_blue, out_green, out_red);
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d pending", quiet_cycles, mixed_q.size());
      $display("[video_transition_mixer] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_dissolve_rounding();
    test_wipe_edges();
    test_box_edges();
    test_degenerate_sizes();
    test_random_mixes();
    test_full_rate();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("mixed %0d pixels over %0d register settings in all four modes,",
             n_sent, n_settings);
    $display("checked %0d output beats, %0d mismatches", n_checked, errors);
    if (errors == 0 && mixed_q.size() == 0) begin
      $display("[video_transition_mixer] OK");
    end else begin
      $display("[video_transition_mixer] ERROR");
    end
    $finish;
  end

endmodule
